// ----- hw/rtl/pbdh_pkg.sv -----
// Shared types and constants for the pairwise binned difference histogram.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package pbdh_pkg;

  // Sizing
  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_AW   = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = SAMPLE_AW + 1;
  localparam int MAX_BINS    = 1024;
  localparam int BIN_AW      = $clog2(MAX_BINS);
  localparam int NB_W        = 11;
  localparam logic [NB_W-1:0] NB_RESET = 11'd1000;
  localparam int COUNT_W     = 23;
  localparam logic [COUNT_W-1:0] COUNT_CAP = 23'h7FFFFF;

  // Divider and bin number widths
  localparam int DIV_W = 48;   // dividend and quotient
  localparam int DSR_W = 40;   // divisor and remainder
  localparam int MAG_W = 42;   // bin number magnitude
  localparam int BIN_W = MAG_W + 1;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_CLIP = 2'd2;
  localparam logic [1:0] ST_OVER = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] sample_value;
    logic               last_sample;
    logic [9:0]         bin_index;
  } in_item_t;

  typedef struct packed {
    logic [22:0] pair_count;
    logic [31:0] bin_width;
    logic        done_res;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_RANGE, S_WSTART, S_WDIV, S_ZWR,
    S_BRD, S_BMUL, S_BDSTART, S_BDIV,
    S_PI, S_PI2, S_PA, S_PB, S_PC, S_PD, S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_write;
    logic rng_latch;
    logic div_start;
    logic div_sel_bin;
    logic width_latch;
    logic zero_write;
    logic smp_read;
    logic mul_latch;
    logic bin_write;
    logic bin_rd_i;
    logic bin_rd_j;
    logic bin_i_latch;
    logic diff_latch;
    logic hist_rd_pair;
    logic pair_write;
    logic pass_end;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic range_zero;
    logic div_done;
    logic i_last;
    logic j_last;
    logic n_lt2;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pbdh_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on pbdh_pkg for operand widths.
`default_nettype none

module pbdh_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pbdh_pkg::DIV_W-1:0] dividend,
  input  logic [pbdh_pkg::DSR_W-1:0] divisor,
  output logic                       done,
  output logic [pbdh_pkg::DIV_W-1:0] quotient
);
  import pbdh_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic            running;
  logic [CW-1:0]   cnt;
  logic [DSR_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DSR_W:0]  shifted;
  logic [DSR_W:0]  diffv;
  logic            fits;

  // Trial subtract
  assign shifted = {rem, quo[DIV_W-1]};
  assign diffv   = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};
  assign quotient = quo;

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      rem <= fits ? diffv[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pbdh_datapath.sv -----
// Datapath: sample, bin number and histogram memories, min/max tracking,
// bin width and bin number arithmetic. Depends on pbdh_pkg and pbdh_div.
`default_nettype none

module pbdh_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  pbdh_pkg::in_item_t        item,
  input  pbdh_pkg::ctrl_cmd_t       cmd,
  input  logic                      cfg_we,
  input  logic [pbdh_pkg::NB_W-1:0] cfg_data,
  output pbdh_pkg::dp_status_t      sts,
  output pbdh_pkg::out_item_t       result_data
);
  import pbdh_pkg::*;

  // Memories
  logic [31:0]        sample_mem [MAX_SAMPLES];
  logic [BIN_W-1:0]   bin_mem    [MAX_SAMPLES];
  logic [COUNT_W-1:0] hist_mem   [MAX_BINS];

  // Control state
  logic [NB_W-1:0]      bin_count;
  logic [CNT_W-1:0]     n_loaded;
  logic signed [31:0]   min_q;
  logic signed [31:0]   max_q;
  logic [31:0]          width_q;
  logic [1:0]           status_q;
  logic                 done_q;
  logic                 stale;
  logic                 rd_valid;
  logic                 range_zero;
  logic                 clipped;
  logic [SAMPLE_AW-1:0] i_q;
  logic [SAMPLE_AW-1:0] j_q;
  logic [BIN_AW-1:0]    clr_addr;

  // Payload registers
  logic [NB_W-1:0]    nb_q;
  logic [16:0]        mul_q;
  logic [38:0]        den_q;
  logic [COUNT_W-1:0] pairs_q;
  logic [31:0]        smp_rd;
  logic [BIN_W-1:0]   bin_rd;
  logic [COUNT_W-1:0] hist_rd;
  logic [DIV_W-1:0]   prod_q;
  logic               neg_q;
  logic [BIN_W-1:0]   bin_i_q;
  logic [BIN_AW-1:0]  d_q;

  // Combinational
  logic               is_load;
  logic               is_read;
  logic               first;
  logic               room;
  logic [32:0]        rng_full;
  logic [NB_W-1:0]    nb_c;
  logic [CNT_W-1:0]   n_m1;
  logic [2*CNT_W-1:0] pair_prod;
  logic [2*CNT_W-2:0] pair_half;
  logic [31:0]        x_abs;
  logic [48:0]        prod_full;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [DIV_W-1:0]   div_a;
  logic [DSR_W-1:0]   div_b;
  logic [MAG_W:0]     bin_mag;
  logic [BIN_W-1:0]   bin_val;
  logic [BIN_W:0]     diff;
  logic [BIN_W:0]     diff_mag;
  logic [NB_W-1:0]    lim;
  logic               clip;
  logic               hist_we;
  logic [BIN_AW-1:0]  hist_wa;
  logic [COUNT_W-1:0] hist_wd;

  assign is_load = cmd.accept && (item.operation == OP_LOAD);
  assign is_read = cmd.accept && (item.operation == OP_READ);
  assign first   = (n_loaded == '0);
  assign room    = n_loaded < CNT_W'(MAX_SAMPLES);

  // Range and clamped bin count
  assign rng_full = {max_q[31], max_q} - {min_q[31], min_q};
  always_comb begin
    if (bin_count == '0) nb_c = NB_W'(1);
    else if (bin_count > NB_W'(MAX_BINS)) nb_c = NB_W'(MAX_BINS);
    else nb_c = bin_count;
  end

  // Pair total for the zero range case
  assign n_m1      = n_loaded - 1'b1;
  assign pair_prod = {{CNT_W{1'b0}}, n_loaded} * {{CNT_W{1'b0}}, n_m1};
  assign pair_half = pair_prod[2*CNT_W-1:1];

  // Sample magnitude times nb*100
  assign x_abs     = smp_rd[31] ? (~smp_rd + 32'd1) : smp_rd;
  assign prod_full = {17'b0, x_abs} * {32'b0, mul_q};

  // Shared divider: width = range*101 / (nb*100), bin = |x|*nb*100 / (range*101)
  assign div_a = cmd.div_sel_bin ? prod_q : {9'b0, den_q};
  assign div_b = cmd.div_sel_bin ? {1'b0, den_q} : {23'b0, mul_q};

  pbdh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Signed bin number, truncated toward zero
  assign bin_mag = {1'b0, div_q[MAG_W-1:0]};
  assign bin_val = neg_q ? (~bin_mag + 1'b1) : bin_mag;

  // Bin difference and clip
  assign diff     = {bin_i_q[BIN_W-1], bin_i_q} - {bin_rd[BIN_W-1], bin_rd};
  assign diff_mag = diff[BIN_W] ? (~diff + 1'b1) : diff;
  assign lim      = nb_q - 1'b1;
  assign clip     = diff_mag > {{(BIN_W+1-NB_W){1'b0}}, lim};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count  <= NB_RESET;
      n_loaded   <= '0;
      min_q      <= '0;
      max_q      <= '0;
      width_q    <= '0;
      status_q   <= ST_OK;
      done_q     <= 1'b0;
      stale      <= 1'b1;
      rd_valid   <= 1'b0;
      range_zero <= 1'b0;
      clipped    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      clr_addr   <= '0;
    end else begin
      if (cfg_we) bin_count <= cfg_data;
      rd_valid <= is_read && !stale;

      // Sample load
      if (is_load) begin
        if (first) begin
          stale    <= 1'b1;
          done_q   <= 1'b0;
          status_q <= ST_OK;
        end
        if (room) begin
          if (first || (item.sample_value < min_q)) min_q <= item.sample_value;
          if (first || (item.sample_value > max_q)) max_q <= item.sample_value;
          n_loaded <= n_loaded + 1'b1;
        end else begin
          status_q <= ST_OVER;
        end
      end

      if (cmd.clr_write) clr_addr <= clr_addr + 1'b1;

      if (cmd.rng_latch) begin
        range_zero <= (rng_full[31:0] == '0);
        clipped    <= 1'b0;
        i_q        <= '0;
      end

      if (cmd.width_latch)
        width_q <= (div_q[DIV_W-1:32] != '0) ? '1 : div_q[31:0];

      if (cmd.bin_write) begin
        i_q <= sts.i_last ? SAMPLE_AW'(1) : i_q + 1'b1;
        j_q <= '0;
      end

      if (cmd.diff_latch && clip) clipped <= 1'b1;

      if (cmd.pair_write) begin
        if (sts.j_last) begin
          i_q <= i_q + 1'b1;
          j_q <= '0;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end

      if (cmd.pass_end) begin
        if (status_q != ST_OVER)
          status_q <= range_zero ? ST_ZERO : (clipped ? ST_CLIP : ST_OK);
        done_q   <= 1'b1;
        n_loaded <= '0;
        stale    <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.rng_latch) begin
      nb_q    <= nb_c;
      mul_q   <= 17'(nb_c) * 17'd100;
      den_q   <= {7'b0, rng_full[31:0]} * 39'd101;
      pairs_q <= (pair_half > (2*CNT_W-1)'(COUNT_CAP)) ? COUNT_CAP
                                                      : pair_half[COUNT_W-1:0];
    end
    if (cmd.mul_latch) begin
      prod_q <= prod_full[DIV_W-1:0];
      neg_q  <= smp_rd[31];
    end
    if (cmd.bin_i_latch) bin_i_q <= bin_rd;
    if (cmd.diff_latch) d_q <= clip ? lim[BIN_AW-1:0] : diff_mag[BIN_AW-1:0];
  end

  // Sample memory
  always_ff @(posedge clk) begin
    if (is_load && room) sample_mem[n_loaded[SAMPLE_AW-1:0]] <= item.sample_value;
    if (cmd.smp_read) smp_rd <= sample_mem[i_q];
  end

  // Bin number memory
  always_ff @(posedge clk) begin
    if (cmd.bin_write) bin_mem[i_q] <= bin_val;
    if (cmd.bin_rd_i || cmd.bin_rd_j) bin_rd <= bin_mem[cmd.bin_rd_i ? i_q : j_q];
  end

  // Histogram memory: clear sweep, zero range total, pair increments
  assign hist_we = cmd.clr_write || cmd.zero_write || cmd.pair_write;
  always_comb begin
    if (cmd.clr_write) begin
      hist_wa = clr_addr;
      hist_wd = '0;
    end else if (cmd.zero_write) begin
      hist_wa = '0;
      hist_wd = pairs_q;
    end else begin
      hist_wa = d_q;
      hist_wd = (hist_rd == COUNT_CAP) ? COUNT_CAP : hist_rd + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    if (is_read || cmd.hist_rd_pair)
      hist_rd <= hist_mem[is_read ? item.bin_index : d_q];
  end

  // Status to controller
  assign sts.clr_last   = (clr_addr == '1);
  assign sts.range_zero = range_zero;
  assign sts.div_done   = div_done;
  assign sts.i_last     = (i_q == n_m1[SAMPLE_AW-1:0]);
  assign sts.j_last     = (j_q == i_q - 1'b1);
  assign sts.n_lt2      = (n_loaded < CNT_W'(2));

  // Result payload
  assign result_data.pair_count = rd_valid ? hist_rd : '0;
  assign result_data.bin_width  = width_q;
  assign result_data.done_res   = done_q;
  assign result_data.status     = status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pbdh_ctrl.sv -----
// Controller state machine: sequences clear, width, bin and pair phases.
// Depends on pbdh_pkg.
`default_nettype none

module pbdh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  pbdh_pkg::in_item_t   item,
  input  pbdh_pkg::dp_status_t sts,
  output pbdh_pkg::ctrl_cmd_t  cmd,
  output logic                 busy,
  output logic                 result_strobe
);
  import pbdh_pkg::*;

  state_t state;
  state_t state_next;
  logic   pass_go;

  assign pass_go = (item.operation == OP_LOAD) && item.last_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= (cmd.accept && !pass_go) || cmd.pass_end;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (start && pass_go) state_next = S_CLEAR;
      S_CLEAR:   if (sts.clr_last) state_next = S_RANGE;
      S_RANGE:   state_next = S_WSTART;
      S_WSTART:  state_next = S_WDIV;
      S_WDIV:    if (sts.div_done) state_next = sts.range_zero ? S_ZWR : S_BRD;
      S_ZWR:     state_next = S_FINISH;
      S_BRD:     state_next = S_BMUL;
      S_BMUL:    state_next = S_BDSTART;
      S_BDSTART: state_next = S_BDIV;
      S_BDIV: begin
        if (sts.div_done) begin
          if (!sts.i_last) state_next = S_BRD;
          else state_next = sts.n_lt2 ? S_FINISH : S_PI;
        end
      end
      S_PI:      state_next = S_PI2;
      S_PI2:     state_next = S_PB;
      S_PA:      state_next = S_PB;
      S_PB:      state_next = S_PC;
      S_PC:      state_next = S_PD;
      S_PD: begin
        if (sts.j_last && sts.i_last) state_next = S_FINISH;
        else if (sts.j_last) state_next = S_PI;
        else state_next = S_PA;
      end
      S_FINISH:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd  = '0;
    busy = (state != S_IDLE);
    case (state)
      S_IDLE:    cmd.accept = start;
      S_CLEAR:   cmd.clr_write = 1'b1;
      S_RANGE:   cmd.rng_latch = 1'b1;
      S_WSTART:  cmd.div_start = 1'b1;
      S_WDIV:    cmd.width_latch = sts.div_done;
      S_ZWR:     cmd.zero_write = 1'b1;
      S_BRD:     cmd.smp_read = 1'b1;
      S_BMUL:    cmd.mul_latch = 1'b1;
      S_BDSTART: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_bin = 1'b1;
      end
      S_BDIV: begin
        cmd.div_sel_bin = 1'b1;
        cmd.bin_write   = sts.div_done;
      end
      S_PI:      cmd.bin_rd_i = 1'b1;
      S_PI2: begin
        cmd.bin_i_latch = 1'b1;
        cmd.bin_rd_j    = 1'b1;
      end
      S_PA:      cmd.bin_rd_j = 1'b1;
      S_PB:      cmd.diff_latch = 1'b1;
      S_PC:      cmd.hist_rd_pair = 1'b1;
      S_PD:      cmd.pair_write = 1'b1;
      S_FINISH:  cmd.pass_end = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pairwise_binned_difference_histogram_top.sv -----
// Top level of the pairwise binned difference histogram.
// Depends on pbdh_pkg, pbdh_ctrl and pbdh_datapath.
//
// Usage: a request is taken when start is high and busy is low. A load
// (operation 0) stores one signed Q16.16 sample and tracks min/max; a read
// (operation 1) returns the count of bin bin_index. Every request yields one
// result on result, marked by result_strobe for a single cycle; the receiver
// cannot stall it. Loads and reads without the last mark never raise busy,
// so one request per cycle; each result comes the cycle after its transfer.
// A load with last_sample set runs the pair pass while busy is high:
// histogram clear, bin width, bin numbers from the bit-serial divider,
// then each pair through the histogram read-modify-write port; a zero
// range skips the bin and pair phases. Its result follows the pass.
// bin_count is written over cfg_valid/cfg_ready (always ready); the user
// must write it only while idle, as the block does not enforce this.
// Reset returns to idle, bin_count to 1000, and reads return zero until the
// first pass completes.
`default_nettype none

module pairwise_binned_difference_histogram_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  pbdh_pkg::in_item_t        request,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pbdh_pkg::NB_W-1:0] cfg_data,
  output logic                      result_strobe,
  output pbdh_pkg::out_item_t       result
);
  import pbdh_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  pbdh_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .item          (request),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy),
    .result_strobe (result_strobe)
  );

  pbdh_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (request),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .sts         (sts),
    .result_data (result)
  );

`ifndef SYNTHESIS
  // A final load always enters the pair pass
  a_pass_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.operation == OP_LOAD && request.last_sample) |=> busy)
    else $error("final load did not start the pair pass");

  // Results only appear while idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> !busy)
    else $error("result strobe while busy");

  // The result following a pass reports a complete histogram
  a_pass_done: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && $past(busy)) |-> result.done_res)
    else $error("pass result without done");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for pairwise_binned_difference_histogram_top.
// Depends on pbdh_pkg and the RTL under hw/rtl; predicts every result in-line
// and compares each strobed result with the oldest prediction.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pbdh_pkg::*;

  localparam int ITEM_GOAL   = 1650;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    request;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [NB_W-1:0] cfg_data;
  logic        result_strobe;
  out_item_t   result;

  pairwise_binned_difference_histogram_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_strobe(result_strobe), .result(result)
  );

  // Predictor state
  int unsigned     hist_model [MAX_BINS];
  logic [31:0]     sample_mem [MAX_SAMPLES];
  longint          bin_num [MAX_SAMPLES];
  int unsigned     loaded;
  logic signed [31:0] min_seen;
  logic signed [31:0] max_seen;
  logic [31:0]     width_model;
  logic [1:0]      status_model;
  logic            ready_model;
  logic [NB_W-1:0] nbins_model;

  out_item_t expected_results [$];
  int        mismatches;
  int        items_sent;
  longint    cycles;
  bit        no_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pair pass: bin width, bin numbers, pair differences
  function automatic void run_pair_pass();
    longint nb;
    longint span;
    longint unsigned w;
    longint unsigned pairs;
    longint d;
    bit clipped;
    nb = nbins_model;
    clipped = 0;
    if (nb == 0) nb = 1;
    if (nb > MAX_BINS) nb = MAX_BINS;
    span = longint'(max_seen) - longint'(min_seen);
    if (span < 0) span = 0;
    w = longint'(span * 101) / (nb * 100);
    width_model = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    if (span == 0) begin
      pairs = (loaded > 1) ? (longint'(loaded) * (loaded - 1)) / 2 : 0;
      hist_model[0] = (pairs > COUNT_CAP) ? COUNT_CAP : pairs;
      if (status_model != ST_OVER) status_model = ST_ZERO;
    end else begin
      for (int i = 0; i < loaded; i++)
        bin_num[i] = (longint'($signed(sample_mem[i])) * (nb * 100)) / (span * 101);
      for (int i = 1; i < loaded; i++) begin
        for (int j = 0; j < i; j++) begin
          d = bin_num[i] - bin_num[j];
          if (d < 0) d = -d;
          if (d > nb - 1) begin
            d = nb - 1;
            clipped = 1;
          end
          if (hist_model[d] < COUNT_CAP) hist_model[d]++;
        end
      end
      if (status_model != ST_OVER) status_model = clipped ? ST_CLIP : ST_OK;
    end
    loaded = 0;
    ready_model = 1'b1;
  endfunction

  // Expected result of one accepted request
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t r;
    r.pair_count = '0;
    if (it.operation == OP_LOAD) begin
      if (loaded == 0) begin
        foreach (hist_model[k]) hist_model[k] = 0;
        status_model = ST_OK;
        ready_model = 1'b0;
        min_seen = it.sample_value;
        max_seen = it.sample_value;
      end
      if (loaded < MAX_SAMPLES) begin
        sample_mem[loaded] = it.sample_value;
        if (it.sample_value < min_seen) min_seen = it.sample_value;
        if (it.sample_value > max_seen) max_seen = it.sample_value;
        loaded++;
      end else begin
        status_model = ST_OVER;
      end
      if (it.last_sample) run_pair_pass();
    end else begin
      r.pair_count = hist_model[it.bin_index];
    end
    r.bin_width = width_model;
    r.done_res  = ready_model;
    r.status    = status_model;
    return r;
  endfunction

  // Result check, config tracking and prediction at each edge
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      foreach (hist_model[k]) hist_model[k] = 0;
      loaded = 0;
      min_seen = 0;
      max_seen = 0;
      width_model = 0;
      status_model = ST_OK;
      ready_model = 1'b0;
      nbins_model = NB_RESET;
    end else begin
      if (result_strobe) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          exp_r = expected_results.pop_front();
          if (result.pair_count !== exp_r.pair_count || result.bin_width !== exp_r.bin_width
              || result.done_res !== exp_r.done_res || result.status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: count %0d/%0d width %h/%h done %b/%b status %0d/%0d",
                       exp_r.pair_count, result.pair_count, exp_r.bin_width,
                       result.bin_width, exp_r.done_res, result.done_res,
                       exp_r.status, result.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) nbins_model = cfg_data;
      if (start && !busy) expected_results = {expected_results, predict_result(request)};
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pairwise_binned_difference_histogram_top verification failed");
      $finish;
    end
  end

  // Send one request and wait for its transfer, then maybe idle
  task automatic send_item(logic op, logic [31:0] value, logic last, logic [9:0] idx);
    int gap;
    in_item_t it;
    it.operation = op;
    it.sample_value = value;
    it.last_sample = last;
    it.bin_index = idx;
    request <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_bin_count(logic [NB_W-1:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic read_bin(logic [9:0] idx);
    send_item(OP_READ, $urandom, $urandom_range(0, 1), idx);
  endtask

  // Directed: extremes, zero range, clipping, out-of-range bin counts
  task automatic test_directed();
    read_bin(0);
    write_bin_count(1);
    send_item(OP_LOAD, 32'h8000_0000, 1'b0, 10'd0);
    send_item(OP_LOAD, 32'h7FFF_FFFF, 1'b1, 10'd0);
    read_bin(0);
    write_bin_count(1024);
    send_item(OP_LOAD, 32'h7FFF_FFFF, 1'b0, 10'h3FF);
    send_item(OP_LOAD, 32'h8000_0000, 1'b0, 10'h3FF);
    send_item(OP_LOAD, 32'h0000_0000, 1'b1, 10'h3FF);
    read_bin(10'h3FF);
    read_bin(512);
    read_bin(0);
    // single sample and duplicate samples: zero range
    send_item(OP_LOAD, 32'h0001_0000, 1'b1, 10'd0);
    read_bin(0);
    send_item(OP_LOAD, 32'hFFFF_0000, 1'b0, 10'd0);
    send_item(OP_LOAD, 32'hFFFF_0000, 1'b1, 10'd0);
    read_bin(0);
    // bin count 0 acts as 1; high sample lands past the last bin
    write_bin_count(0);
    send_item(OP_LOAD, 32'h0032_0000, 1'b0, 10'd0);
    send_item(OP_LOAD, 32'h0064_0000, 1'b1, 10'd0);
    read_bin(0);
    write_bin_count(11'h7FF);
    send_item(OP_LOAD, 32'h0000_0000, 1'b0, 10'd0);
    send_item(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 10'd0);
    send_item(OP_LOAD, 32'h0000_0001, 1'b1, 10'd0);
    read_bin(1);
  endtask

  // Random sets: mostly small, clustered or spread, some with duplicates
  task automatic test_random_sets();
    int n;
    int mode;
    int set_no;
    logic [31:0] base;
    logic [31:0] v;
    set_no = 0;
    while (items_sent < ITEM_GOAL) begin
      set_no++;
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 4))
          0: write_bin_count(1);
          1: write_bin_count(1024);
          2: write_bin_count($urandom_range(0, 2047));
          default: write_bin_count($urandom_range(1, 16));
        endcase
      end
      // hold off until the block is fully quiet now and then
      if (set_no % 20 == 0) drain();
      no_gaps = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 49))
        0: n = 60;
        1, 2, 3, 4: n = $urandom_range(13, 30);
        default: n = $urandom_range(1, 12);
      endcase
      mode = $urandom_range(0, 3);
      base = $urandom;
      for (int i = 0; i < n; i++) begin
        case (mode)
          0: v = $urandom;
          1: v = base + $urandom_range(0, 32'h0003_0000);
          2: v = base + $urandom_range(0, 3) * 32'h0001_0000;
          default: v = $urandom_range(0, 1) ? base : $urandom;
        endcase
        send_item(OP_LOAD, v, i == n - 1, $urandom);
        if ($urandom_range(0, 19) == 0) read_bin($urandom);
      end
      repeat ($urandom_range(1, 8))
        read_bin($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    no_gaps = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_sets();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("pairwise_binned_difference_histogram_top verification clean");
    end else begin
      $display("pairwise_binned_difference_histogram_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
